// File: sv/atr_pkg.sv
`timescale 1ns / 1ps
// Shared types, response codes and token tables for the response token recognizer.
// No dependencies; used by atr_match and at_response_token_recognizer.
package atr_pkg;

	localparam int POS_W  = 5;
	localparam int CODE_W = 3;

	typedef logic [POS_W-1:0]  pos_t;
	typedef logic [CODE_W-1:0] code_t;
	typedef logic [7:0]        byte_t;

	// Response codes
	localparam code_t CODE_NONE  = 3'd0;
	localparam code_t CODE_OK    = 3'd1;
	localparam code_t CODE_ERROR = 3'd2;
	localparam code_t CODE_FAIL  = 3'd3;
	localparam code_t CODE_READY = 3'd4;
	localparam code_t CODE_WRITE = 3'd5;

	// Characters that matter
	localparam byte_t CH_CR    = 8'h0d;
	localparam byte_t CH_LF    = 8'h0a;
	localparam byte_t CH_SPACE = 8'h20;
	localparam byte_t CH_O     = 8'h4f;
	localparam byte_t CH_E     = 8'h45;
	localparam byte_t CH_F     = 8'h46;
	localparam byte_t CH_R_LO  = 8'h72;
	localparam byte_t CH_GT    = 8'h3e;

	// Match positions: idle, first position of each token, and the last valid one
	localparam pos_t POS_IDLE  = 5'd0;
	localparam pos_t POS_OK    = 5'd1;
	localparam pos_t POS_ERROR = 5'd4;
	localparam pos_t POS_FAIL  = 5'd10;
	localparam pos_t POS_READY = 5'd15;
	localparam pos_t POS_WRITE = 5'd21;
	localparam pos_t POS_LAST  = 5'd21;

	// Position reached when a token starts with this byte (idle if none does)
	function automatic pos_t start_pos(input byte_t b);
		pos_t p;
		unique case (b)
			CH_O:    p = POS_OK;
			CH_E:    p = POS_ERROR;
			CH_F:    p = POS_FAIL;
			CH_R_LO: p = POS_READY;
			CH_GT:   p = POS_WRITE;
			default: p = POS_IDLE;
		endcase
		return p;
	endfunction

	// Byte expected at a position inside a token
	function automatic byte_t want_byte(input pos_t p);
		byte_t b;
		unique case (p)
			5'd1:  b = 8'h4b; // K
			5'd2:  b = CH_CR;
			5'd3:  b = CH_LF;
			5'd4:  b = 8'h52; // R
			5'd5:  b = 8'h52; // R
			5'd6:  b = 8'h4f; // O
			5'd7:  b = 8'h52; // R
			5'd8:  b = CH_CR;
			5'd9:  b = CH_LF;
			5'd10: b = 8'h41; // A
			5'd11: b = 8'h49; // I
			5'd12: b = 8'h4c; // L
			5'd13: b = CH_CR;
			5'd14: b = CH_LF;
			5'd15: b = 8'h65; // e
			5'd16: b = 8'h61; // a
			5'd17: b = 8'h64; // d
			5'd18: b = 8'h79; // y
			5'd19: b = CH_CR;
			5'd20: b = CH_LF;
			5'd21: b = CH_SPACE;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

	// Code given when the byte at this position completes a token
	function automatic code_t done_code(input pos_t p);
		code_t c;
		unique case (p)
			5'd3:    c = CODE_OK;
			5'd9:    c = CODE_ERROR;
			5'd14:   c = CODE_FAIL;
			5'd20:   c = CODE_READY;
			5'd21:   c = CODE_WRITE;
			default: c = CODE_NONE;
		endcase
		return c;
	endfunction

endpackage

// File: sv/at_response_token_recognizer.sv
`timescale 1ns / 1ps
// Top level of the modem response token recognizer: input and result registers.
// Depends on atr_pkg and atr_match.
//
// Usage:
//   Input channel (in_valid / in_ready / rx_byte) takes one received byte per beat.
//   Output channel (out_valid / out_ready / response_code) gives one code per
//   input beat, in order: 0 none, 1 ok, 2 error, 3 fail, 4 ready, 5 ready to write.
//   A nonzero code appears only on the beat of the byte that completes a token
//   (the line feed, or the space of "> ").
// Data path:
//   An accepted byte sits in the input register, is matched in one
//   combinational pass and moves into the result register when that register is
//   free or being emptied. One byte per cycle is sustained while out_ready stays high;
//   the match-position register is updated in the same pass that loads the result.
// Reset:
//   arst_n clears both stage valids and returns the match position to idle.
// Stall:
//   While out_ready is low and a result waits, the input register holds its byte;
//   one more byte is still taken if the input register is empty, after which
//   in_ready drops until the result is taken.
module at_response_token_recognizer (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  atr_pkg::byte_t rx_byte,
	output logic           out_valid,
	input  logic           out_ready,
	output atr_pkg::code_t response_code
);
	import atr_pkg::*;

	logic  valid_s1;
	byte_t byte_s1;
	logic  valid_s2;
	code_t code_s2;
	logic  advance;
	logic  step;
	code_t code_d;

	// advance the pipe whenever the result register is free or being emptied
	assign advance  = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || advance;
	assign step     = valid_s1 && advance;

	// input register: hold the byte until it moves into the result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	atr_match u_match (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.rx_byte (byte_s1),
		.code    (code_d)
	);

	// result register: one code per beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			code_s2 <= code_d;
		end
	end

	assign out_valid     = valid_s2;
	assign response_code = code_s2;

	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> code_s2 <= CODE_WRITE)
		else $error("response code out of range");

	a_stall_holds_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(byte_s1))
		else $error("input register lost a byte during a stall");

	a_step_fills_s2: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> valid_s2)
		else $error("matched byte produced no result");

endmodule

// File: sv/atr_match.sv
`timescale 1ns / 1ps
// Match-position register and the single-pass next-state and code logic.
// Depends on atr_pkg.
module atr_match (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  atr_pkg::byte_t rx_byte,
	output atr_pkg::code_t code
);
	import atr_pkg::*;

	pos_t  pos_q;
	pos_t  pos_d;
	code_t code_d;
	logic  hit;

	assign hit = (pos_q <= POS_LAST) && (rx_byte == want_byte(pos_q));

	always_comb begin
		pos_d  = POS_IDLE;
		code_d = CODE_NONE;
		priority if (pos_q == POS_IDLE) begin
			pos_d = start_pos(rx_byte);
		end else if (hit) begin
			code_d = done_code(pos_q);
			// advance unless this byte ends the token
			pos_d  = (code_d != CODE_NONE) ? POS_IDLE : pos_q + 5'd1;
		end else begin
			// mismatch: drop the byte and go idle
			pos_d = POS_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= POS_IDLE;
		end else if (step) begin
			pos_q <= pos_d;
		end
	end

	assign code = code_d;

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_LAST)
		else $error("match position out of range");

	a_done_idles: assert property (@(posedge clk) disable iff (!arst_n)
		step && code_d != CODE_NONE |=> pos_q == POS_IDLE)
		else $error("completed token did not return to idle");

	a_inside_advance: assert property (@(posedge clk) disable iff (!arst_n)
		step && pos_q != POS_IDLE |=> pos_q == POS_IDLE || pos_q == $past(pos_q) + 5'd1)
		else $error("match position jumped inside a token");

endmodule
